// File: hw/rtl/tcpu_pkg.sv
// Shared types and constants for the tiny CPU execute unit.
// Holds opcodes, decoded operation kinds, queue depths and the
// structs passed between front end, back end and result queue.
package tcpu_pkg;

   localparam int REG_COUNT = 16;
   localparam int REG_AW    = $clog2(REG_COUNT);

   // Decoded-op queue and result queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Opcode bytes
   localparam logic [7:0] OPC_INC  = 8'h01;
   localparam logic [7:0] OPC_DEC  = 8'h02;
   localparam logic [7:0] OPC_MOV  = 8'h03;
   localparam logic [7:0] OPC_LDI  = 8'h04;
   localparam logic [7:0] OPC_SHL  = 8'h05;
   localparam logic [7:0] OPC_SHR  = 8'h06;
   localparam logic [7:0] OPC_JMP  = 8'h07;
   localparam logic [7:0] OPC_JZ   = 8'h08;
   localparam logic [7:0] OPC_JNZ  = 8'h09;
   localparam logic [7:0] OPC_JEND = 8'h0A;
   localparam logic [7:0] OPC_HALT = 8'h0B;
   localparam logic [7:0] OPC_ADD  = 8'h0C;
   localparam logic [7:0] OPC_SUB  = 8'h0D;
   localparam logic [7:0] OPC_XOR  = 8'h0E;
   localparam logic [7:0] OPC_OR   = 8'h0F;
   localparam logic [7:0] OPC_IN   = 8'h10;
   localparam logic [7:0] OPC_OUT  = 8'h11;

   // Decoded operation kinds
   localparam int KIND_W = 5;
   localparam logic [KIND_W-1:0] KIND_NOP  = 5'd0;
   localparam logic [KIND_W-1:0] KIND_INC  = 5'd1;
   localparam logic [KIND_W-1:0] KIND_DEC  = 5'd2;
   localparam logic [KIND_W-1:0] KIND_MOV  = 5'd3;
   localparam logic [KIND_W-1:0] KIND_LDI  = 5'd4;
   localparam logic [KIND_W-1:0] KIND_SHL  = 5'd5;
   localparam logic [KIND_W-1:0] KIND_SHR  = 5'd6;
   localparam logic [KIND_W-1:0] KIND_JMP  = 5'd7;
   localparam logic [KIND_W-1:0] KIND_JZ   = 5'd8;
   localparam logic [KIND_W-1:0] KIND_JNZ  = 5'd9;
   localparam logic [KIND_W-1:0] KIND_JEND = 5'd10;
   localparam logic [KIND_W-1:0] KIND_HALT = 5'd11;
   localparam logic [KIND_W-1:0] KIND_ADD  = 5'd12;
   localparam logic [KIND_W-1:0] KIND_SUB  = 5'd13;
   localparam logic [KIND_W-1:0] KIND_XOR  = 5'd14;
   localparam logic [KIND_W-1:0] KIND_OR   = 5'd15;
   localparam logic [KIND_W-1:0] KIND_IN   = 5'd16;
   localparam logic [KIND_W-1:0] KIND_OUT  = 5'd17;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [REG_AW-1:0] dst;
      logic [REG_AW-1:0] src;
      logic [7:0]        arg;
      logic [7:0]        in_byte;
      logic              in_at_end;
   } uop_type;

   typedef struct packed {
      logic [7:0] next_pc;
      logic       out_valid;
      logic [7:0] out_byte;
      logic       halted;
      logic       zero_seen;
      logic       end_seen;
   } rsp_type;

endpackage

// File: hw/rtl/tcpu_front.sv
// Front end: accepts instructions, decodes them into operation kinds
// and buffers them in a short queue. Depends on tcpu_pkg.
module tcpu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        mode,
   input  logic [7:0]        operand,
   input  logic [7:0]        in_byte,
   input  logic              in_at_end,
   output logic              deq_valid,
   output tcpu_pkg::uop_type deq_uop,
   input  logic              deq
);

   tcpu_pkg::uop_type                 q_mem_ff [tcpu_pkg::QUEUE_DEPTH];
   logic [tcpu_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tcpu_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tcpu_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   tcpu_pkg::uop_type                 dec_uop;
   logic                              accept;

   localparam logic [tcpu_pkg::QPTR_W-1:0] PTR_LAST = tcpu_pkg::QPTR_W'(tcpu_pkg::QUEUE_DEPTH - 1);
   localparam logic [tcpu_pkg::QCNT_W-1:0] CNT_FULL = tcpu_pkg::QCNT_W'(tcpu_pkg::QUEUE_DEPTH);

   always_comb begin
      dec_uop.dst       = operand[tcpu_pkg::REG_AW-1:0];
      dec_uop.src       = operand[7:4];
      dec_uop.arg       = operand;
      dec_uop.in_byte   = in_byte;
      dec_uop.in_at_end = in_at_end;
      case (mode)
         tcpu_pkg::OPC_INC:  dec_uop.kind = tcpu_pkg::KIND_INC;
         tcpu_pkg::OPC_DEC:  dec_uop.kind = tcpu_pkg::KIND_DEC;
         tcpu_pkg::OPC_MOV:  dec_uop.kind = tcpu_pkg::KIND_MOV;
         tcpu_pkg::OPC_LDI:  dec_uop.kind = tcpu_pkg::KIND_LDI;
         tcpu_pkg::OPC_SHL:  dec_uop.kind = tcpu_pkg::KIND_SHL;
         tcpu_pkg::OPC_SHR:  dec_uop.kind = tcpu_pkg::KIND_SHR;
         tcpu_pkg::OPC_JMP:  dec_uop.kind = tcpu_pkg::KIND_JMP;
         tcpu_pkg::OPC_JZ:   dec_uop.kind = tcpu_pkg::KIND_JZ;
         tcpu_pkg::OPC_JNZ:  dec_uop.kind = tcpu_pkg::KIND_JNZ;
         tcpu_pkg::OPC_JEND: dec_uop.kind = tcpu_pkg::KIND_JEND;
         tcpu_pkg::OPC_HALT: dec_uop.kind = tcpu_pkg::KIND_HALT;
         tcpu_pkg::OPC_ADD:  dec_uop.kind = tcpu_pkg::KIND_ADD;
         tcpu_pkg::OPC_SUB:  dec_uop.kind = tcpu_pkg::KIND_SUB;
         tcpu_pkg::OPC_XOR:  dec_uop.kind = tcpu_pkg::KIND_XOR;
         tcpu_pkg::OPC_OR:   dec_uop.kind = tcpu_pkg::KIND_OR;
         tcpu_pkg::OPC_IN:   dec_uop.kind = tcpu_pkg::KIND_IN;
         tcpu_pkg::OPC_OUT:  dec_uop.kind = tcpu_pkg::KIND_OUT;
         default:            dec_uop.kind = tcpu_pkg::KIND_NOP;
      endcase
      // load constant always targets r0
      if (dec_uop.kind == tcpu_pkg::KIND_LDI) begin
         dec_uop.dst = '0;
      end
   end

   assign full      = (cnt_ff == CNT_FULL);
   assign accept    = push && !full;
   assign deq_valid = (cnt_ff != '0);
   assign deq_uop   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({accept, deq})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_mem_ff[wr_ptr_ff] <= dec_uop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/tcpu_back.sv
// Back end: register file read stage followed by the execute stage that
// owns the program counter and flags. Depends on tcpu_pkg.
module tcpu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  tcpu_pkg::uop_type q_uop,
   output logic              q_deq,
   output logic              res_push,
   output tcpu_pkg::rsp_type res_data,
   input  logic              res_ready
);

   logic [7:0]                 rf_mem [tcpu_pkg::REG_COUNT];
   logic [tcpu_pkg::REG_COUNT-1:0] rf_vld_ff, rf_vld_in;

   logic              a_valid_ff, a_valid_in;
   tcpu_pkg::uop_type a_uop_ff;
   logic [7:0]        rd_val_ff;
   logic [7:0]        rs_val_ff;

   logic [7:0] pc_ff, pc_in;
   logic       zf_ff, zf_in;
   logic       ef_ff, ef_in;

   logic       exec_fire;
   logic       issue;
   logic       wr_en;
   logic       wr_fire;
   logic [7:0] wr_val;
   logic [7:0] jump_to;
   logic [7:0] step2;
   logic       out_valid;
   logic       halted;
   logic       fwd_d;
   logic       fwd_s;

   assign exec_fire = a_valid_ff && res_ready;
   assign issue     = q_valid && (!a_valid_ff || exec_fire);
   assign q_deq     = issue;

   always_comb begin
      if (issue) begin
         a_valid_in = 1'b1;
      end else if (exec_fire) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   // execute
   always_comb begin
      jump_to   = pc_ff + a_uop_ff.arg;
      step2     = pc_ff + 8'd2;
      wr_en     = 1'b0;
      wr_val    = '0;
      pc_in     = step2;
      ef_in     = ef_ff;
      out_valid = 1'b0;
      halted    = 1'b0;
      case (a_uop_ff.kind)
         tcpu_pkg::KIND_INC: begin
            wr_en = 1'b1; wr_val = rd_val_ff + 8'd1;
         end
         tcpu_pkg::KIND_DEC: begin
            wr_en = 1'b1; wr_val = rd_val_ff - 8'd1;
         end
         tcpu_pkg::KIND_MOV: begin
            wr_en = 1'b1; wr_val = rs_val_ff;
         end
         tcpu_pkg::KIND_LDI: begin
            wr_en = 1'b1; wr_val = a_uop_ff.arg;
         end
         tcpu_pkg::KIND_SHL: begin
            wr_en = 1'b1; wr_val = {rd_val_ff[6:0], 1'b0};
         end
         tcpu_pkg::KIND_SHR: begin
            wr_en = 1'b1; wr_val = {1'b0, rd_val_ff[7:1]};
         end
         tcpu_pkg::KIND_ADD: begin
            wr_en = 1'b1; wr_val = rd_val_ff + rs_val_ff;
         end
         tcpu_pkg::KIND_SUB: begin
            wr_en = 1'b1; wr_val = rd_val_ff - rs_val_ff;
         end
         tcpu_pkg::KIND_XOR: begin
            wr_en = 1'b1; wr_val = rd_val_ff ^ rs_val_ff;
         end
         tcpu_pkg::KIND_OR: begin
            wr_en = 1'b1; wr_val = rd_val_ff | rs_val_ff;
         end
         tcpu_pkg::KIND_IN: begin
            wr_en = 1'b1; wr_val = a_uop_ff.in_byte;
            ef_in = a_uop_ff.in_at_end;
         end
         tcpu_pkg::KIND_OUT: begin
            out_valid = 1'b1;
         end
         tcpu_pkg::KIND_JMP:  pc_in = jump_to;
         tcpu_pkg::KIND_JZ:   pc_in = zf_ff ? jump_to : step2;
         tcpu_pkg::KIND_JNZ:  pc_in = zf_ff ? step2 : jump_to;
         tcpu_pkg::KIND_JEND: pc_in = ef_ff ? jump_to : step2;
         tcpu_pkg::KIND_HALT: begin
            halted = 1'b1; pc_in = pc_ff;
         end
         default: pc_in = pc_ff;
      endcase
      zf_in = wr_en ? (wr_val == 8'd0) : zf_ff;
   end

   assign wr_fire = exec_fire && wr_en;

   always_comb begin
      rf_vld_in = rf_vld_ff;
      if (wr_fire) begin
         rf_vld_in[a_uop_ff.dst] = 1'b1;
      end
   end

   // bypass a write retiring this cycle into the read stage
   assign fwd_d = wr_fire && (a_uop_ff.dst == q_uop.dst);
   assign fwd_s = wr_fire && (a_uop_ff.dst == q_uop.src);

   assign res_push           = exec_fire;
   assign res_data.next_pc   = pc_in;
   assign res_data.out_valid = out_valid;
   assign res_data.out_byte  = out_valid ? rd_val_ff : 8'd0;
   assign res_data.halted    = halted;
   assign res_data.zero_seen = zf_in;
   assign res_data.end_seen  = ef_in;

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         rf_mem[a_uop_ff.dst] <= wr_val;
      end
      if (issue) begin
         a_uop_ff <= q_uop;
         if (fwd_d) begin
            rd_val_ff <= wr_val;
         end else if (!rf_vld_ff[q_uop.dst]) begin
            rd_val_ff <= '0;
         end else begin
            rd_val_ff <= rf_mem[q_uop.dst];
         end
         if (fwd_s) begin
            rs_val_ff <= wr_val;
         end else if (!rf_vld_ff[q_uop.src]) begin
            rs_val_ff <= '0;
         end else begin
            rs_val_ff <= rf_mem[q_uop.src];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         rf_vld_ff  <= '0;
         pc_ff      <= '0;
         zf_ff      <= 1'b0;
         ef_ff      <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         rf_vld_ff  <= rf_vld_in;
         if (exec_fire) begin
            pc_ff <= pc_in;
            zf_ff <= zf_in;
            ef_ff <= ef_in;
         end
      end
   end

endmodule

// File: hw/rtl/tcpu_rsp_queue.sv
// Result queue between the execute stage and the result ports.
// Depends on tcpu_pkg for the result struct and queue depth.
module tcpu_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcpu_pkg::rsp_type push_data,
   output logic              ready,
   output logic              empty,
   input  logic              pop,
   output tcpu_pkg::rsp_type pop_data
);

   tcpu_pkg::rsp_type           q_mem_ff [tcpu_pkg::QUEUE_DEPTH];
   logic [tcpu_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tcpu_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tcpu_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                        pop_fire;

   localparam logic [tcpu_pkg::QPTR_W-1:0] PTR_LAST = tcpu_pkg::QPTR_W'(tcpu_pkg::QUEUE_DEPTH - 1);
   localparam logic [tcpu_pkg::QCNT_W-1:0] CNT_FULL = tcpu_pkg::QCNT_W'(tcpu_pkg::QUEUE_DEPTH);

   assign empty    = (cnt_ff == '0);
   assign pop_fire = pop && !empty;
   // a full queue still takes a result when the head leaves this cycle
   assign ready    = (cnt_ff != CNT_FULL) || pop_fire;
   assign pop_data = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop_fire})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/tiny_cpu_execute_unit.sv
// Execute unit of a small 8-bit machine: one two-byte instruction per item,
// sixteen registers, program counter, zero and end-of-input flags. It takes
// one instruction per clock when neither side stalls; an accepted instruction
// passes through the decode queue and then the register read stage, and
// execute writes its result straight into the result queue. The register
// read stage, with a bypass from the execute stage, sets the one-per-clock
// rate. Halt is not sticky; unknown opcodes change nothing.
module tiny_cpu_execute_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_mode,
   input  logic [7:0] req_operand,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_at_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_next_pc,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_halted,
   output logic       rsp_zero_seen,
   output logic       rsp_end_seen
);

   logic              deq_valid;
   logic              deq;
   tcpu_pkg::uop_type deq_uop;
   logic              res_push;
   logic              res_ready;
   tcpu_pkg::rsp_type res_data;
   tcpu_pkg::rsp_type rsp_data;

   tcpu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .mode      (req_mode),
      .operand   (req_operand),
      .in_byte   (req_in_byte),
      .in_at_end (req_in_at_end),
      .deq_valid (deq_valid),
      .deq_uop   (deq_uop),
      .deq       (deq)
   );

   tcpu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (deq_valid),
      .q_uop     (deq_uop),
      .q_deq     (deq),
      .res_push  (res_push),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

   tcpu_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .ready     (res_ready),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (rsp_data)
   );

   assign rsp_next_pc   = rsp_data.next_pc;
   assign rsp_out_valid = rsp_data.out_valid;
   assign rsp_out_byte  = rsp_data.out_byte;
   assign rsp_halted    = rsp_data.halted;
   assign rsp_zero_seen = rsp_data.zero_seen;
   assign rsp_end_seen  = rsp_data.end_seen;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_halt_no_out: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_halted && rsp_out_valid))
      else $error("halt result also carries an output byte");

   a_out_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_out_valid) |-> (rsp_out_byte == 8'd0))
      else $error("output byte nonzero without OUT");

   a_no_dequeue_empty: assert property (@(posedge clock) disable iff (reset)
      deq |-> deq_valid)
      else $error("back end took an op from an empty decode queue");
`endif

endmodule

// File: verif/tiny_cpu_execute_unit_test.sv
// Self-checking testbench for tiny_cpu_execute_unit: a directed table, then random
// instruction streams, checked against an in-bench model of the machine state.
// Depends on tcpu_pkg for the opcode constants and the result struct.
module tiny_cpu_execute_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]        mode;
      logic [7:0]        operand;
      logic [7:0]        in_byte;
      logic              in_at_end;
      logic              known;
      tcpu_pkg::rsp_type rsp;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 630;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_mode = '0;
   logic [7:0] req_operand = '0;
   logic [7:0] req_in_byte = '0;
   logic       req_in_at_end = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_next_pc;
   logic       rsp_out_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_halted;
   logic       rsp_zero_seen;
   logic       rsp_end_seen;

   // machine state as the model sees it
   logic [7:0] reg_bank [tcpu_pkg::REG_COUNT];
   logic [7:0] model_pc;
   logic       model_zero;
   logic       model_end;

   tcpu_pkg::rsp_type pending_rsp [$];
   stim_row_type      dir_rows [DIRECTED_ROWS];
   int                mismatch_count = 0;
   int                hold_left = 0;
   bit                no_idle = 1'b0;

   tiny_cpu_execute_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_mode     (req_mode),
      .req_operand  (req_operand),
      .req_in_byte  (req_in_byte),
      .req_in_at_end(req_in_at_end),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_next_pc  (rsp_next_pc),
      .rsp_out_valid(rsp_out_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_halted   (rsp_halted),
      .rsp_zero_seen(rsp_zero_seen),
      .rsp_end_seen (rsp_end_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic tcpu_pkg::rsp_type exec_instr(
         input logic [7:0] mode, input logic [7:0] operand,
         input logic [7:0] in_byte, input logic in_at_end);
      tcpu_pkg::rsp_type res;
      logic [3:0]        d;
      logic [7:0]        rd, rs, val, pc_hop, pc_step;
      logic              wr;
      d       = operand[3:0];
      rd      = reg_bank[operand[3:0]];
      rs      = reg_bank[operand[7:4]];
      pc_hop  = model_pc + operand;
      pc_step = model_pc + 8'd2;
      res     = '0;
      wr      = 1'b0;
      val     = '0;
      case (mode)
         tcpu_pkg::OPC_INC: begin val = rd + 8'd1; wr = 1'b1; end
         tcpu_pkg::OPC_DEC: begin val = rd - 8'd1; wr = 1'b1; end
         tcpu_pkg::OPC_MOV: begin val = rs; wr = 1'b1; end
         tcpu_pkg::OPC_LDI: begin d = '0; val = operand; wr = 1'b1; end
         tcpu_pkg::OPC_SHL: begin val = {rd[6:0], 1'b0}; wr = 1'b1; end
         tcpu_pkg::OPC_SHR: begin val = {1'b0, rd[7:1]}; wr = 1'b1; end
         tcpu_pkg::OPC_ADD: begin val = rd + rs; wr = 1'b1; end
         tcpu_pkg::OPC_SUB: begin val = rd - rs; wr = 1'b1; end
         tcpu_pkg::OPC_XOR: begin val = rd ^ rs; wr = 1'b1; end
         tcpu_pkg::OPC_OR:  begin val = rd | rs; wr = 1'b1; end
         tcpu_pkg::OPC_IN: begin
            val = in_byte;
            wr = 1'b1;
            model_end = in_at_end;
         end
         tcpu_pkg::OPC_OUT: begin
            res.out_valid = 1'b1;
            res.out_byte = rd;
            model_pc = pc_step;
         end
         tcpu_pkg::OPC_JMP:  model_pc = pc_hop;
         tcpu_pkg::OPC_JZ:   model_pc = model_zero ? pc_hop : pc_step;
         tcpu_pkg::OPC_JNZ:  model_pc = model_zero ? pc_step : pc_hop;
         tcpu_pkg::OPC_JEND: model_pc = model_end ? pc_hop : pc_step;
         tcpu_pkg::OPC_HALT: res.halted = 1'b1;
         default: ;
      endcase
      if (wr) begin
         reg_bank[d] = val;
         model_zero = (val == 8'h00);
         model_pc = pc_step;
      end
      res.next_pc   = model_pc;
      res.zero_seen = model_zero;
      res.end_seen  = model_end;
      return res;
   endfunction

   task automatic send_instr(input stim_row_type row);
      tcpu_pkg::rsp_type model_rsp;
      int                gap;
      gap = no_idle ? 0 : idle_len();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_mode      <= row.mode;
      req_operand   <= row.operand;
      req_in_byte   <= row.in_byte;
      req_in_at_end <= row.in_at_end;
      @(posedge clock);
      while (req_full) @(posedge clock);
      model_rsp = exec_instr(row.mode, row.operand, row.in_byte, row.in_at_end);
      pending_rsp.push_back(row.known ? row.rsp : model_rsp);
   endtask

   // result side: check each transfer, then decide whether to pop next cycle
   always @(posedge clock) begin
      tcpu_pkg::rsp_type got, want;
      if (reset) begin
         rsp_pop <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_next_pc, rsp_out_valid, rsp_out_byte, rsp_halted,
                    rsp_zero_seen, rsp_end_seen};
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: pc=%h ov=%b ob=%h halt=%b z=%b e=%b",
                           got.next_pc, got.out_valid, got.out_byte, got.halted,
                           got.zero_seen, got.end_seen);
            end else begin
               want = pending_rsp.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch at %0t: expected pc=%h ov=%b ob=%h",
                               " halt=%b z=%b e=%b,",
                               " got pc=%h ov=%b ob=%h halt=%b z=%b e=%b"}, $realtime,
                              want.next_pc, want.out_valid, want.out_byte, want.halted,
                              want.zero_seen, want.end_seen,
                              got.next_pc, got.out_valid, got.out_byte, got.halted,
                              got.zero_seen, got.end_seen);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (!no_idle) hold_left = idle_len();
         end
      end
   end

   initial begin
      stim_row_type row;
      int           pick;
      for (int i = 0; i < tcpu_pkg::REG_COUNT; i++) reg_bank[i] = '0;
      model_pc   = '0;
      model_zero = 1'b0;
      model_end  = 1'b0;

      // fields: mode, operand, in_byte, in_at_end, known,
      //         {next_pc, out_valid, out_byte, halted, zero_seen, end_seen}
      dir_rows[0]  = '{tcpu_pkg::OPC_HALT, 8'h00, 8'h00, 1'b0, 1'b1,
                       '{8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0}};
      dir_rows[1]  = '{8'h00, 8'hFF, 8'h00, 1'b0, 1'b1,
                       '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}};
      // unknown opcode must also ignore the IN-only fields
      dir_rows[2]  = '{8'hFF, 8'h5A, 8'hFF, 1'b1, 1'b1,
                       '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}};
      dir_rows[3]  = '{tcpu_pkg::OPC_LDI, 8'hFF, 8'h00, 1'b0, 1'b1,
                       '{8'h02, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}};
      // r0 wraps from 0xFF to zero
      dir_rows[4]  = '{tcpu_pkg::OPC_INC, 8'h00, 8'h00, 1'b0, 1'b1,
                       '{8'h04, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}};
      // taken jump with zero offset stays put
      dir_rows[5]  = '{tcpu_pkg::OPC_JZ, 8'h00, 8'h00, 1'b0, 1'b1,
                       '{8'h04, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}};
      dir_rows[6]  = '{tcpu_pkg::OPC_JNZ, 8'h10, 8'h00, 1'b0, 1'b1,
                       '{8'h06, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}};
      dir_rows[7]  = '{tcpu_pkg::OPC_DEC, 8'h01, 8'h00, 1'b0, 1'b1,
                       '{8'h08, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}};
      dir_rows[8]  = '{tcpu_pkg::OPC_OUT, 8'h01, 8'h00, 1'b0, 1'b1,
                       '{8'h0A, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0}};
      dir_rows[9]  = '{tcpu_pkg::OPC_JEND, 8'h7F, 8'h00, 1'b0, 1'b1,
                       '{8'h0C, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}};
      dir_rows[10] = '{tcpu_pkg::OPC_IN, 8'h02, 8'h00, 1'b1, 1'b1,
                       '{8'h0E, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}};
      // most negative offset, then a forward jump that wraps past 0xFF
      dir_rows[11] = '{tcpu_pkg::OPC_JEND, 8'h80, 8'h00, 1'b0, 1'b1,
                       '{8'h8E, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}};
      dir_rows[12] = '{tcpu_pkg::OPC_JMP, 8'h72, 8'h00, 1'b0, 1'b1,
                       '{8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}};
      dir_rows[13] = '{tcpu_pkg::OPC_JMP, 8'hFE, 8'h00, 1'b0, 1'b1,
                       '{8'hFE, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}};
      dir_rows[14] = '{tcpu_pkg::OPC_LDI, 8'h80, 8'h00, 1'b0, 1'b1,
                       '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}};
      dir_rows[15] = '{tcpu_pkg::OPC_SHL, 8'h00, 8'h00, 1'b0, 1'b1,
                       '{8'h02, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}};
      dir_rows[16] = '{tcpu_pkg::OPC_SHR,  8'h01, 8'h00, 1'b0, 1'b0, '0};
      dir_rows[17] = '{tcpu_pkg::OPC_MOV,  8'h1F, 8'h00, 1'b0, 1'b0, '0};
      dir_rows[18] = '{tcpu_pkg::OPC_ADD,  8'hF1, 8'h00, 1'b0, 1'b0, '0};
      dir_rows[19] = '{tcpu_pkg::OPC_SUB,  8'h1F, 8'h00, 1'b0, 1'b0, '0};
      dir_rows[20] = '{tcpu_pkg::OPC_XOR,  8'hFF, 8'h00, 1'b0, 1'b0, '0};
      dir_rows[21] = '{tcpu_pkg::OPC_OR,   8'h1E, 8'h00, 1'b0, 1'b0, '0};
      dir_rows[22] = '{tcpu_pkg::OPC_IN,   8'hF3, 8'hFF, 1'b0, 1'b0, '0};
      dir_rows[23] = '{tcpu_pkg::OPC_OUT,  8'h0F, 8'h00, 1'b0, 1'b0, '0};
      dir_rows[24] = '{tcpu_pkg::OPC_JNZ,  8'h81, 8'hFF, 1'b1, 1'b0, '0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) send_instr(dir_rows[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // hold both sides busy for a stretch in the middle
         no_idle = (n >= 300 && n < 380);
         pick = $urandom_range(0, 99);
         if (pick < 88) row.mode = 8'($urandom_range(1, 17));
         else row.mode = 8'($urandom_range(0, 255));
         row.operand = 8'($urandom);
         // same source and destination drives SUB and XOR to zero
         if ($urandom_range(0, 5) == 0) row.operand[7:4] = row.operand[3:0];
         row.in_byte = 8'($urandom);
         if ($urandom_range(0, 5) == 0) row.in_byte = 8'h00;
         row.in_at_end = 1'($urandom);
         row.known = 1'b0;
         row.rsp = '0;
         send_instr(row);
      end
      req_push <= 1'b0;
      no_idle = 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("tiny_cpu_execute_unit regression: pass");
      end else begin
         $display("tiny_cpu_execute_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tiny_cpu_execute_unit regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/tcpu_pkg.sv
hw/rtl/tcpu_front.sv
hw/rtl/tcpu_back.sv
hw/rtl/tcpu_rsp_queue.sv
hw/rtl/tiny_cpu_execute_unit.sv
verif/tiny_cpu_execute_unit_test.sv
